>>> hdl/alfp_pkg.sv
// Shared types and codes for the array linked list with free pool.
`timescale 1ns / 1ps

package alfp_pkg;

  typedef enum logic [1:0] {
    OP_PUSH     = 2'd0,
    OP_POP      = 2'd1,
    OP_APPEND   = 2'd2,
    OP_TRAVERSE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    RD_FREE = 2'd0,
    RD_HEAD = 2'd1,
    RD_NEXT = 2'd2,
    RD_CUR  = 2'd3
  } rd_sel_e;

  typedef struct packed {
    logic    in_ready;
    logic    capture;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    take;
    logic    take_link_head;
    logic    head_take;
    logic    cur_load_head;
    logic    cur_advance;
    logic    link_wr_tail;
    logic    pop;
    logic    emit;
    status_e emit_status;
    logic    emit_has;
    logic    emit_last;
  } alfp_cmd_t;

  typedef struct packed {
    op_e  op;
    logic full;
    logic empty;
    logic link_end;
    logic cnt_lt_cap;
    logic cnt_last;
    logic out_free;
  } alfp_sts_t;

endpackage

>>> hdl/alfp_if.sv
// Request and result channel interfaces of the linked list pool.
`timescale 1ns / 1ps

interface alfp_req_if;
  import alfp_pkg::*;

  logic               valid;
  logic               ready;
  op_e                operation;
  logic signed [31:0] in_value;

  modport source (output valid, output operation, output in_value, input ready);
  modport sink (input valid, input operation, input in_value, output ready);
endinterface

interface alfp_rsp_if;
  import alfp_pkg::*;

  logic               valid;
  logic               ready;
  logic signed [31:0] out_value;
  logic               has_value;
  logic               last;
  status_e            status;
  logic               is_empty;
  logic               is_full;

  modport source (
    output valid, output out_value, output has_value, output last,
    output status, output is_empty, output is_full, input ready
  );
  modport sink (
    input valid, input out_value, input has_value, input last,
    input status, input is_empty, input is_full, output ready
  );
endinterface

>>> hdl/array_linked_list_free_pool.sv
// Top level of the array linked list with free pool: controller plus datapath.
// Push is sequenced through dispatch, take and done, pop through dispatch, pop and done;
// rejections and a traverse of an empty list give their result straight from dispatch.
// Append goes from take to done on an empty list, else walks the links to the tail first.
// Traverse gives one element per cycle while the result register is free, paced by
// the single read port of the node memories; one request is in work at a time.
`timescale 1ns / 1ps

module array_linked_list_free_pool #(
  parameter int CAPACITY = 32
) (
  input logic        clk_i,
  input logic        rst_ni,
  alfp_req_if.sink   req_i,
  alfp_rsp_if.source rsp_o
);
  import alfp_pkg::*;

  alfp_cmd_t cmd;
  alfp_sts_t sts;

  alfp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  alfp_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .operation_i (req_i.operation),
    .in_value_i  (req_i.in_value),
    .out_ready_i (rsp_o.ready),
    .out_valid_o (rsp_o.valid),
    .out_value_o (rsp_o.out_value),
    .has_value_o (rsp_o.has_value),
    .last_o      (rsp_o.last),
    .status_o    (rsp_o.status),
    .is_empty_o  (rsp_o.is_empty),
    .is_full_o   (rsp_o.is_full)
  );

  assign req_i.ready = cmd.in_ready;

endmodule

>>> hdl/alfp_ctrl.sv
// Sequencing state machine of the linked list pool.
`timescale 1ns / 1ps

module alfp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  alfp_pkg::alfp_sts_t  sts_i,
  output alfp_pkg::alfp_cmd_t  cmd_o
);
  import alfp_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_TAKE     = 3'd2;
  localparam logic [2:0] S_WALK     = 3'd3;
  localparam logic [2:0] S_POP      = 3'd4;
  localparam logic [2:0] S_DONE     = 3'd5;
  localparam logic [2:0] S_TRAV     = 3'd6;

  logic [2:0] state_q, state_d;
  logic       trav_last;

  assign trav_last = sts_i.link_end || sts_i.cnt_last;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts_i.op) inside
          OP_PUSH, OP_APPEND: begin
            if (sts_i.full) begin
              if (sts_i.out_free) begin
                cmd_o.emit        = 1'b1;
                cmd_o.emit_status = ST_FULL;
                cmd_o.emit_last   = 1'b1;
                state_d           = S_IDLE;
              end
            end else begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = RD_FREE;
              state_d      = S_TAKE;
            end
          end
          OP_POP: begin
            if (sts_i.empty) begin
              if (sts_i.out_free) begin
                cmd_o.emit        = 1'b1;
                cmd_o.emit_status = ST_EMPTY;
                cmd_o.emit_last   = 1'b1;
                state_d           = S_IDLE;
              end
            end else begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = RD_HEAD;
              state_d      = S_POP;
            end
          end
          default: begin
            if (sts_i.empty) begin
              if (sts_i.out_free) begin
                cmd_o.emit        = 1'b1;
                cmd_o.emit_status = ST_OK;
                cmd_o.emit_last   = 1'b1;
                state_d           = S_IDLE;
              end
            end else begin
              cmd_o.rd_en         = 1'b1;
              cmd_o.rd_sel        = RD_HEAD;
              cmd_o.cur_load_head = 1'b1;
              state_d             = S_TRAV;
            end
          end
        endcase
      end
      S_TAKE: begin
        cmd_o.take = 1'b1;
        if (sts_i.op == OP_PUSH) begin
          cmd_o.take_link_head = 1'b1;
          cmd_o.head_take      = 1'b1;
          state_d              = S_DONE;
        end else if (sts_i.empty) begin
          cmd_o.head_take = 1'b1;
          state_d         = S_DONE;
        end else begin
          cmd_o.cur_load_head = 1'b1;
          cmd_o.rd_en         = 1'b1;
          cmd_o.rd_sel        = RD_HEAD;
          state_d             = S_WALK;
        end
      end
      S_WALK: begin
        if (!sts_i.link_end && sts_i.cnt_lt_cap) begin
          cmd_o.cur_advance = 1'b1;
          cmd_o.rd_en       = 1'b1;
          cmd_o.rd_sel      = RD_NEXT;
        end else begin
          cmd_o.link_wr_tail = 1'b1;
          state_d            = S_DONE;
        end
      end
      S_POP: begin
        cmd_o.pop = 1'b1;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = ST_OK;
          cmd_o.emit_last   = 1'b1;
          state_d           = S_IDLE;
        end
      end
      S_TRAV: begin
        cmd_o.rd_en = 1'b1;
        if (sts_i.out_free) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = ST_OK;
          cmd_o.emit_has    = 1'b1;
          cmd_o.emit_last   = trav_last;
          if (trav_last) begin
            cmd_o.rd_en = 1'b0;
            state_d     = S_IDLE;
          end else begin
            cmd_o.cur_advance = 1'b1;
            cmd_o.rd_sel      = RD_NEXT;
          end
        end else begin
          cmd_o.rd_sel = RD_CUR;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hdl/alfp_dp.sv
// Datapath of the linked list pool: node memories, pointers and result register.
`timescale 1ns / 1ps

module alfp_dp #(
  parameter int CAPACITY = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  alfp_pkg::alfp_cmd_t  cmd_i,
  output alfp_pkg::alfp_sts_t  sts_o,
  input  alfp_pkg::op_e        operation_i,
  input  logic signed [31:0]   in_value_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic signed [31:0]   out_value_o,
  output logic                 has_value_o,
  output logic                 last_o,
  output alfp_pkg::status_e    status_o,
  output logic                 is_empty_o,
  output logic                 is_full_o
);
  import alfp_pkg::*;

  localparam int IW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [IW-1:0] CAP_IDX = IW'(CAPACITY);

  logic [IW-1:0]      link_mem [CAPACITY];
  logic [31:0]        value_mem [CAPACITY];
  logic [CAPACITY-1:0] link_vld_q;

  op_e                op_q;
  logic signed [31:0] val_q;
  logic [IW-1:0]      head_q, free_q, new_q, cur_q, cnt_q;
  logic [IW-1:0]      link_rd_q;
  logic               link_vld_rd_q;
  logic [AW-1:0]      raddr_q;
  logic [31:0]        value_rd_q;

  logic [IW-1:0]      link_rdata;
  logic [IW-1:0]      raddr;
  logic               link_we;
  logic [IW-1:0]      link_waddr, link_wdata;
  logic [IW:0]        cnt_inc;
  logic               out_free;

  logic               out_valid_q;
  logic signed [31:0] out_value_q;
  logic               has_value_q, last_q, is_empty_q, is_full_q;
  status_e            status_q;

  assign link_rdata = link_vld_rd_q ? link_rd_q : (IW'(raddr_q) + IW'(1));

  always_comb begin
    case (cmd_i.rd_sel)
      RD_FREE: raddr = free_q;
      RD_HEAD: raddr = head_q;
      RD_NEXT: raddr = link_rdata;
      default: raddr = cur_q;
    endcase
  end

  always_comb begin
    link_we    = 1'b0;
    link_waddr = free_q;
    link_wdata = CAP_IDX;
    if (cmd_i.take) begin
      link_we    = 1'b1;
      link_waddr = free_q;
      link_wdata = cmd_i.take_link_head ? head_q : CAP_IDX;
    end else if (cmd_i.link_wr_tail) begin
      link_we    = 1'b1;
      link_waddr = cur_q;
      link_wdata = new_q;
    end else if (cmd_i.pop) begin
      link_we    = 1'b1;
      link_waddr = head_q;
      link_wdata = free_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_waddr[AW-1:0]] <= link_wdata;
    end
    if (cmd_i.take) begin
      value_mem[free_q[AW-1:0]] <= val_q;
    end
    if (cmd_i.rd_en) begin
      link_rd_q     <= link_mem[raddr[AW-1:0]];
      value_rd_q    <= value_mem[raddr[AW-1:0]];
      link_vld_rd_q <= link_vld_q[raddr[AW-1:0]];
      raddr_q       <= raddr[AW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_vld_q <= '0;
      head_q     <= CAP_IDX;
      free_q     <= '0;
    end else begin
      if (link_we) begin
        link_vld_q[link_waddr[AW-1:0]] <= 1'b1;
      end
      if (cmd_i.take) begin
        free_q <= link_rdata;
        if (cmd_i.head_take) begin
          head_q <= free_q;
        end
      end else if (cmd_i.pop) begin
        head_q <= link_rdata;
        free_q <= head_q;
      end
    end
  end

  assign cnt_inc = {1'b0, cnt_q} + (IW + 1)'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= operation_i;
      val_q <= in_value_i;
    end
    if (cmd_i.take) begin
      new_q <= free_q;
    end
    if (cmd_i.cur_load_head) begin
      cur_q <= head_q;
      cnt_q <= '0;
    end else if (cmd_i.cur_advance) begin
      cur_q <= link_rdata;
      cnt_q <= cnt_inc[IW-1:0];
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    sts_o.op         = op_q;
    sts_o.full       = free_q >= CAP_IDX;
    sts_o.empty      = head_q >= CAP_IDX;
    sts_o.link_end   = link_rdata >= CAP_IDX;
    sts_o.cnt_lt_cap = cnt_q < CAP_IDX;
    sts_o.cnt_last   = cnt_inc >= (IW + 1)'(CAPACITY);
    sts_o.out_free   = out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_value_q <= cmd_i.emit_has ? value_rd_q : '0;
      has_value_q <= cmd_i.emit_has;
      last_q      <= cmd_i.emit_last;
      status_q    <= cmd_i.emit_status;
      is_empty_q  <= head_q >= CAP_IDX;
      is_full_q   <= free_q >= CAP_IDX;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign has_value_o = has_value_q;
  assign last_o      = last_q;
  assign status_o    = status_q;
  assign is_empty_o  = is_empty_q;
  assign is_full_o   = is_full_q;

endmodule

>>> tb/list_pool_checker.sv
// Monitors the request and result channels, predicts the list pool and checks every result.
`timescale 1ns / 1ps

module list_pool_checker #(
  parameter int CAPACITY = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  alfp_req_if  req_mon,
  alfp_rsp_if  rsp_mon,
  output int   fail_count_o,
  output int   pending_o
);
  import alfp_pkg::*;

  typedef struct packed {
    logic signed [31:0] value;
    logic               has;
    logic               last;
    status_e            status;
    logic               empty;
    logic               full;
  } list_rsp_t;

  localparam logic [6:0] END_IDX = 7'(CAPACITY);

  logic signed [31:0] node_val [CAPACITY];
  logic [6:0]         node_nxt [CAPACITY];
  logic [6:0]         head_idx;
  logic [6:0]         free_idx;
  list_rsp_t          rsp_q [$];
  int                 fails;

  function automatic void queue_rsp(logic signed [31:0] value, logic has, logic last,
                                    status_e status);
    list_rsp_t r;
    r.value  = value;
    r.has    = has;
    r.last   = last;
    r.status = status;
    r.empty  = (head_idx >= END_IDX);
    r.full   = (free_idx >= END_IDX);
    rsp_q.push_back(r);
  endfunction

  function automatic logic [6:0] take_node(logic signed [31:0] value);
    logic [6:0] n;
    n = free_idx;
    free_idx = node_nxt[n];
    node_val[n] = value;
    return n;
  endfunction

  function automatic void apply_request(op_e op, logic signed [31:0] value);
    logic [6:0] n;
    logic [6:0] cur;
    int         steps;
    case (op)
      OP_PUSH: begin
        if (free_idx >= END_IDX) begin
          queue_rsp('0, 1'b0, 1'b1, ST_FULL);
        end else begin
          n = take_node(value);
          node_nxt[n] = head_idx;
          head_idx = n;
          queue_rsp('0, 1'b0, 1'b1, ST_OK);
        end
      end
      OP_POP: begin
        if (head_idx >= END_IDX) begin
          queue_rsp('0, 1'b0, 1'b1, ST_EMPTY);
        end else begin
          n = head_idx;
          head_idx = node_nxt[n];
          node_nxt[n] = free_idx;
          free_idx = n;
          queue_rsp('0, 1'b0, 1'b1, ST_OK);
        end
      end
      OP_APPEND: begin
        if (free_idx >= END_IDX) begin
          queue_rsp('0, 1'b0, 1'b1, ST_FULL);
        end else begin
          n = take_node(value);
          node_nxt[n] = END_IDX;
          if (head_idx >= END_IDX) begin
            head_idx = n;
          end else begin
            cur = head_idx;
            steps = 0;
            while (node_nxt[cur] < END_IDX && steps < CAPACITY) begin
              cur = node_nxt[cur];
              steps++;
            end
            node_nxt[cur] = n;
          end
          queue_rsp('0, 1'b0, 1'b1, ST_OK);
        end
      end
      default: begin
        if (head_idx >= END_IDX) begin
          queue_rsp('0, 1'b0, 1'b1, ST_OK);
        end else begin
          cur = head_idx;
          steps = 0;
          while (cur < END_IDX && steps < CAPACITY) begin
            queue_rsp(node_val[cur], 1'b1,
                      (node_nxt[cur] >= END_IDX) || (steps + 1 >= CAPACITY), ST_OK);
            cur = node_nxt[cur];
            steps++;
          end
        end
      end
    endcase
  endfunction

  function automatic void note_failure(string what, list_rsp_t exp_r, list_rsp_t got_r);
    fails++;
    if (fails <= 10) begin
      $display("%t %s: expected value=%0d has=%0b last=%0b status=%0d empty=%0b full=%0b",
               $realtime, what, exp_r.value, exp_r.has, exp_r.last, exp_r.status,
               exp_r.empty, exp_r.full);
      $display("%t %s:   actual value=%0d has=%0b last=%0b status=%0d empty=%0b full=%0b",
               $realtime, what, got_r.value, got_r.has, got_r.last, got_r.status,
               got_r.empty, got_r.full);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    list_rsp_t got_r;
    list_rsp_t exp_r;
    if (!rst_ni) begin
      for (int i = 0; i < CAPACITY; i++) begin
        node_val[i] = '0;
        node_nxt[i] = 7'(i + 1);
      end
      head_idx = END_IDX;
      free_idx = '0;
      rsp_q.delete();
      fails = 0;
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        got_r.value  = rsp_mon.out_value;
        got_r.has    = rsp_mon.has_value;
        got_r.last   = rsp_mon.last;
        got_r.status = rsp_mon.status;
        got_r.empty  = rsp_mon.is_empty;
        got_r.full   = rsp_mon.is_full;
        if (rsp_q.size() == 0) begin
          note_failure("unexpected result", '0, got_r);
        end else begin
          exp_r = rsp_q.pop_front();
          if (got_r !== exp_r) note_failure("result mismatch", exp_r, got_r);
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        apply_request(req_mon.operation, req_mon.in_value);
      end
    end
    fail_count_o = fails;
    pending_o = rsp_q.size();
  end

endmodule

>>> tb/tb.sv
// Top of the list pool testbench: clock, reset, request and result stimulus, and the verdict.
`timescale 1ns / 1ps

module tb;
  import alfp_pkg::*;

  localparam int CAPACITY     = 32;
  localparam int RANDOM_ITEMS = 350;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int HOLD_CYCLES  = 400;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   snd_idle;
  int   rcv_idle;
  logic long_hold;

  alfp_req_if req ();
  alfp_rsp_if rsp ();

  array_linked_list_free_pool #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  list_pool_checker #(
    .CAPACITY(CAPACITY)
  ) u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_mon     (req),
    .rsp_mon     (rsp),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic send(op_e op, logic signed [31:0] value);
    while ($urandom_range(99) < snd_idle) begin
      req.valid <= 1'b0;
      @(negedge clk_i);
    end
    req.valid     <= 1'b1;
    req.operation <= op;
    req.in_value  <= value;
    do @(posedge clk_i); while (!req.ready);
    @(negedge clk_i);
  endtask

  // Bursts alternate between filling the pool, draining it, and an even mix.
  function automatic op_e pick_op(int mode);
    int r;
    r = $urandom_range(99);
    case (mode)
      0: return (r < 45) ? OP_PUSH : (r < 88) ? OP_APPEND : (r < 93) ? OP_POP : OP_TRAVERSE;
      1: return (r < 70) ? OP_POP : (r < 80) ? OP_PUSH : (r < 88) ? OP_APPEND : OP_TRAVERSE;
      default: return op_e'($urandom_range(3));
    endcase
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(15))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'sd0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int hold_left;
    logic hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        rsp.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp.ready <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    req.valid     = 1'b0;
    req.operation = OP_PUSH;
    req.in_value  = '0;
    rst_ni        = 1'b0;
    snd_idle      = 29;
    rcv_idle      = 81;
    long_hold     = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty list cases, extreme values, and appends onto empty and non-empty lists.
    send(OP_TRAVERSE, 32'sd5);
    send(OP_POP, 32'sd7);
    send(OP_PUSH, 32'sh8000_0000);
    send(OP_PUSH, 32'sh7fff_ffff);
    send(OP_APPEND, 32'sd0);
    send(OP_APPEND, -32'sd1);
    send(OP_APPEND, 32'sh5555_5555);
    send(OP_TRAVERSE, 32'sd0);
    send(OP_POP, 32'sd0);
    send(OP_TRAVERSE, -32'sd1);
    send(OP_POP, 32'sd0);
    send(OP_POP, 32'sd0);
    send(OP_POP, 32'sd0);
    send(OP_POP, 32'sd0);
    send(OP_TRAVERSE, 32'sd0);
    send(OP_APPEND, 32'shaaaa_aaaa);
    send(OP_PUSH, 32'sd1);
    send(OP_APPEND, 32'sh0000_ffff);
    send(OP_TRAVERSE, 32'sd0);
    send(OP_POP, 32'sd0);
    send(OP_POP, 32'sd0);
    send(OP_POP, 32'sd0);
    send(OP_TRAVERSE, 32'sd0);

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == RANDOM_ITEMS / 3) begin
        snd_idle = 81;
        rcv_idle = 29;
      end
      if (k == 2 * RANDOM_ITEMS / 3) begin
        snd_idle  = 0;
        rcv_idle  = 0;
        long_hold = 1'b1;
      end
      send(pick_op((k / 50) % 3), pick_value());
    end
    req.valid <= 1'b0;

    wait (pending == 0);
    repeat (64) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
